[src/pcd_pkg.sv]
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants of the Prufer code decoder: field widths,
// controller states and the command and status groups between the modules.
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam int NODE_W        = 6;   // node label and edge end width
	localparam int CNT_W         = 6;   // occurrence count width
	localparam int NCNT_W        = 7;   // node count register width
	localparam int LOAD_W        = 6;   // loaded label and edge counters
	localparam int MAX_NODES_DEF = 64;
	localparam int NCNT_MIN      = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_RD_LABEL,
		ST_RD_COUNT,
		ST_EMIT,
		ST_FIN_LO,
		ST_FIN_HI
	} state_t;

	typedef struct packed {
		logic load;      // store label, fetch its count
		logic bad;       // report a bad label, drop the load and clear the run state
		logic inc;       // write back incremented count
		logic rd_label;  // fetch stored label of the current edge
		logic rd_count;  // fetch count of that label
		logic emit;      // leaf search, emit edge, update flags
		logic fin_lo;    // find smaller remaining node
		logic fin_hi;    // find larger one, emit final edge
	} cmd_t;

	typedef struct packed {
		logic label_bad;
		logic load_full;
		logic edges_done;
	} status_t;

endpackage

[src/pcd_ctrl.sv]
// ----------------------------------------------------------------------------
// pcd_ctrl
// Controller state machine: sequences label loading, the per-edge fetch and
// search steps and the final edge, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module pcd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  pcd_pkg::status_t status,
	output pcd_pkg::cmd_t    cmd,
	output logic             busy
);

	pcd_pkg::state_t state_q;
	pcd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != pcd_pkg::ST_IDLE);
		unique case (state_q)
			pcd_pkg::ST_IDLE: begin
				if (start) begin
					if (status.label_bad) begin
						cmd.bad = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = pcd_pkg::ST_INC;
					end
				end
			end
			pcd_pkg::ST_INC: begin
				cmd.inc = 1'b1;
				state_d = status.load_full ? pcd_pkg::ST_RD_LABEL : pcd_pkg::ST_IDLE;
			end
			pcd_pkg::ST_RD_LABEL: begin
				cmd.rd_label = 1'b1;
				state_d      = pcd_pkg::ST_RD_COUNT;
			end
			pcd_pkg::ST_RD_COUNT: begin
				cmd.rd_count = 1'b1;
				state_d      = pcd_pkg::ST_EMIT;
			end
			pcd_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = status.edges_done ? pcd_pkg::ST_FIN_LO : pcd_pkg::ST_RD_LABEL;
			end
			pcd_pkg::ST_FIN_LO: begin
				cmd.fin_lo = 1'b1;
				state_d    = pcd_pkg::ST_FIN_HI;
			end
			pcd_pkg::ST_FIN_HI: begin
				cmd.fin_hi = 1'b1;
				state_d    = pcd_pkg::ST_IDLE;
			end
			default: begin
				state_d = pcd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[src/pcd_datapath.sv]
// ----------------------------------------------------------------------------
// pcd_datapath
// Label store, occurrence count memory, nonzero and removed flags, leaf
// priority search and the registered result outputs.
// ----------------------------------------------------------------------------
module pcd_datapath #(
	parameter int MAX_NODES = pcd_pkg::MAX_NODES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pcd_pkg::NCNT_W-1:0] cfg_wdata,
	input  logic [pcd_pkg::NODE_W-1:0] label,
	input  pcd_pkg::cmd_t              cmd,
	output pcd_pkg::status_t           status,
	output logic [pcd_pkg::NODE_W-1:0] node_a,
	output logic [pcd_pkg::NODE_W-1:0] node_b,
	output logic                       bad_label,
	output logic                       last,
	output logic                       result_strobe
);

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int SDEPTH = MAX_NODES - 2;
	localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam logic [pcd_pkg::NCNT_W-1:0] NCNT_MAX = pcd_pkg::NCNT_W'(MAX_NODES);
	localparam logic [pcd_pkg::NCNT_W-1:0] NCNT_LO  = pcd_pkg::NCNT_W'(pcd_pkg::NCNT_MIN);

	// lowest set bit, zero when none
	function automatic logic [IDX_W-1:0] find_first(input logic [MAX_NODES-1:0] v);
		logic [IDX_W-1:0] res;
		res = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (v[i]) begin
				res = IDX_W'(i);
			end
		end
		return res;
	endfunction

	logic [pcd_pkg::NCNT_W-1:0] node_cnt_q;
	logic [pcd_pkg::LOAD_W-1:0] loaded_q;
	logic [pcd_pkg::LOAD_W-1:0] edge_q;
	logic [MAX_NODES-1:0]       nz_q;
	logic [MAX_NODES-1:0]       removed_q;
	logic [IDX_W-1:0]           cur_q;
	logic [IDX_W-1:0]           a_q;
	logic [IDX_W-1:0]           lo_q;
	logic [pcd_pkg::NODE_W-1:0] store_mem [SDEPTH];
	logic [pcd_pkg::NODE_W-1:0] store_rd_q;
	logic [pcd_pkg::CNT_W-1:0]  occ_mem [MAX_NODES];
	logic [pcd_pkg::CNT_W-1:0]  occ_rd_q;
	logic                       strobe_q;

	logic [pcd_pkg::NCNT_W-1:0] len_w;
	logic [pcd_pkg::NCNT_W-1:0] cfg_clamp_w;
	logic [MAX_NODES-1:0]       rng_w;
	logic [MAX_NODES-1:0]       leaf_w;
	logic [MAX_NODES-1:0]       alive_w;
	logic [MAX_NODES-1:0]       alive_hi_w;
	logic [IDX_W-1:0]           leaf_idx_w;
	logic [IDX_W-1:0]           lo_idx_w;
	logic [IDX_W-1:0]           hi_idx_w;
	logic [IDX_W-1:0]           occ_raddr_w;
	logic [IDX_W-1:0]           occ_waddr_w;
	logic [pcd_pkg::CNT_W-1:0]  cnt_w;
	logic [pcd_pkg::CNT_W-1:0]  cnt_new_w;
	logic                       clr_w;

	assign len_w = node_cnt_q - pcd_pkg::NCNT_W'(2);
	assign clr_w = cfg_we | cmd.bad | cmd.fin_hi;

	always_comb begin
		if (cfg_wdata < NCNT_LO) begin
			cfg_clamp_w = NCNT_LO;
		end else if (cfg_wdata > NCNT_MAX) begin
			cfg_clamp_w = NCNT_MAX;
		end else begin
			cfg_clamp_w = cfg_wdata;
		end
	end

	assign status.label_bad  = ({1'b0, label} >= node_cnt_q);
	assign status.load_full  = (({1'b0, loaded_q} + pcd_pkg::NCNT_W'(1)) == len_w);
	assign status.edges_done = (({1'b0, edge_q} + pcd_pkg::NCNT_W'(1)) == len_w);

	always_comb begin
		for (int j = 0; j < MAX_NODES; j++) begin
			rng_w[j] = (pcd_pkg::NCNT_W'(j) < node_cnt_q);
		end
	end

	assign leaf_w     = ~removed_q & ~nz_q & rng_w;
	assign alive_w    = ~removed_q & rng_w;
	assign leaf_idx_w = find_first(leaf_w);
	assign lo_idx_w   = find_first(alive_w);

	always_comb begin
		alive_hi_w        = alive_w;
		alive_hi_w[lo_q]  = 1'b0;
	end
	assign hi_idx_w = find_first(alive_hi_w);

	// count read-modify-write; a clear flag means the entry is zero
	assign occ_raddr_w = cmd.load ? label[IDX_W-1:0] : store_rd_q[IDX_W-1:0];
	assign occ_waddr_w = cmd.inc ? cur_q : a_q;
	assign cnt_w       = nz_q[occ_waddr_w] ? occ_rd_q : '0;
	assign cnt_new_w   = cmd.inc ? (cnt_w + pcd_pkg::CNT_W'(1)) : (cnt_w - pcd_pkg::CNT_W'(1));

	always_ff @(posedge clk) begin
		occ_rd_q <= occ_mem[occ_raddr_w];
		if (cmd.inc || cmd.emit) begin
			occ_mem[occ_waddr_w] <= cnt_new_w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			store_mem[loaded_q[SA_W-1:0]] <= label;
		end
		if (cmd.rd_label) begin
			store_rd_q <= store_mem[edge_q[SA_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= label[IDX_W-1:0];
		end
		if (cmd.rd_count) begin
			a_q <= store_rd_q[IDX_W-1:0];
		end
		if (cmd.fin_lo) begin
			lo_q <= lo_idx_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_cnt_q <= NCNT_LO;
			loaded_q   <= '0;
			edge_q     <= '0;
			nz_q       <= '0;
			removed_q  <= '0;
		end else begin
			if (cfg_we) begin
				node_cnt_q <= cfg_clamp_w;
			end
			if (clr_w) begin
				loaded_q  <= '0;
				edge_q    <= '0;
				nz_q      <= '0;
				removed_q <= '0;
			end else begin
				if (cmd.inc) begin
					loaded_q    <= loaded_q + pcd_pkg::LOAD_W'(1);
					edge_q      <= '0;
					nz_q[cur_q] <= 1'b1;
				end
				if (cmd.emit) begin
					edge_q               <= edge_q + pcd_pkg::LOAD_W'(1);
					nz_q[a_q]            <= (cnt_new_w != '0);
					removed_q[leaf_idx_w] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.bad | cmd.emit | cmd.fin_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bad) begin
			node_a    <= '0;
			node_b    <= '0;
			bad_label <= 1'b1;
			last      <= 1'b1;
		end else if (cmd.emit) begin
			node_a    <= pcd_pkg::NODE_W'(a_q);
			node_b    <= pcd_pkg::NODE_W'(leaf_idx_w);
			bad_label <= 1'b0;
			last      <= 1'b0;
		end else if (cmd.fin_hi) begin
			node_a    <= pcd_pkg::NODE_W'(lo_q);
			node_b    <= pcd_pkg::NODE_W'(hi_idx_w);
			bad_label <= 1'b0;
			last      <= 1'b1;
		end
	end

	assign result_strobe = strobe_q;

endmodule

[src/prufer_code_decoder_unit.sv]
// ----------------------------------------------------------------------------
// prufer_code_decoder_unit
// Prufer sequence decoder: loads node_count-2 labels, then emits the
// node_count-1 tree edges in order, final edge flagged by last.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  input     | start, busy               | label
//  result    | result_strobe (no stall)  | node_a, node_b, bad_label, last
//  config    | cfg_we                    | cfg_wdata (node_count)
//
//  a label transaction is a store write and count fetch, then the count
//  write-back; a bad label is reported in the next cycle
//  after the last label each edge is a label fetch, a count fetch and a leaf
//  search with flag update; the final edge is a search for the smaller and
//  then the larger remaining node; the receiver cannot stall the results
//  reset clears the run state and sets node_count to 3; busy is low after reset
// ----------------------------------------------------------------------------
module prufer_code_decoder_unit #(
	parameter int MAX_NODES = pcd_pkg::MAX_NODES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [pcd_pkg::NODE_W-1:0] label,
	input  logic                       cfg_we,
	input  logic [pcd_pkg::NCNT_W-1:0] cfg_wdata,
	output logic                       result_strobe,
	output logic [pcd_pkg::NODE_W-1:0] node_a,
	output logic [pcd_pkg::NODE_W-1:0] node_b,
	output logic                       bad_label,
	output logic                       last
);

	pcd_pkg::cmd_t    cmd;
	pcd_pkg::status_t status;

	pcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	pcd_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.label         (label),
		.cmd           (cmd),
		.status        (status),
		.node_a        (node_a),
		.node_b        (node_b),
		.bad_label     (bad_label),
		.last          (last),
		.result_strobe (result_strobe)
	);

	// a bad label is reported in the very next cycle
	a_bad_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && status.label_bad |=> result_strobe && bad_label && last)
		else $error("bad label not reported");

	// the final edge arrives once the controller is back at rest
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last && !bad_label |-> !busy)
		else $error("final edge while still busy");

	// intermediate edges only while a run is in progress
	a_edge_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |-> busy)
		else $error("edge transaction outside a run");

endmodule
